// File: rtl/dss_pkg.sv
`default_nettype none
package dss_pkg;

  localparam int INITIAL_CAPACITY = 10;
  localparam int MAX_GROWS        = 3;
  localparam int MAX_CAPACITY     = 33;
  localparam int KEY_WIDTH        = 32;

  // capacity after reset, clamped to what the store holds
  localparam int RESET_CAPACITY =
    (INITIAL_CAPACITY > MAX_CAPACITY) ? MAX_CAPACITY : INITIAL_CAPACITY;

  localparam int ADDR_W = (MAX_CAPACITY > 1) ? $clog2(MAX_CAPACITY) : 1;
  localparam int CAP_W  = $clog2(MAX_CAPACITY + 1);
  localparam int GC_W   = (MAX_GROWS > 0) ? $clog2(MAX_GROWS + 1) : 1;

  localparam int REQ_W    = 3;
  localparam int STATUS_W = 3;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_ONE = 3'd0,
    REQ_PUSH_TWO = 3'd1,
    REQ_POP_ONE  = 3'd2,
    REQ_POP_TWO  = 3'd3,
    REQ_GROW     = 3'd4
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_EMPTY   = 3'd2,
    ST_NO_GROW = 3'd3,
    ST_LIMIT   = 3'd4
  } status_t;

  typedef struct packed {
    logic                 valid;
    status_t              status;
    logic [KEY_WIDTH-1:0] pop_value;
    logic [CAP_W-1:0]     capacity;
  } result_t;

endpackage
`default_nettype wire

// File: rtl/dss_ram.sv
`default_nettype none
module dss_ram #(
  parameter int DEPTH = 33,
  parameter int WIDTH = 32,
  parameter int AW    = 6
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: rtl/dss_ctrl.sv
`default_nettype none
module dss_ctrl (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [dss_pkg::REQ_W-1:0]     req_type,
  input  wire logic [dss_pkg::KEY_WIDTH-1:0] push_value,
  output logic                               idle,
  output logic                               mem_we,
  output logic      [dss_pkg::ADDR_W-1:0]    mem_waddr,
  output logic      [dss_pkg::KEY_WIDTH-1:0] mem_wdata,
  output logic      [dss_pkg::ADDR_W-1:0]    mem_raddr,
  input  wire logic [dss_pkg::KEY_WIDTH-1:0] mem_rdata,
  output dss_pkg::result_t                   res
);

  localparam int CW = dss_pkg::CAP_W;
  localparam int AW = dss_pkg::ADDR_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP_WAIT,
    S_MOVE_RD,
    S_MOVE_WR
  } state_t;

  state_t                   state_r, state_nxt;
  logic [CW-1:0]            first_top_r, first_top_nxt;
  logic [CW-1:0]            second_top_r, second_top_nxt;
  logic [CW-1:0]            capacity_r, capacity_nxt;
  logic [dss_pkg::GC_W-1:0] grow_count_r, grow_count_nxt;
  logic [CW-1:0]            src_r, src_nxt;
  logic [CW-1:0]            inc_r, inc_nxt;

  logic [CW:0]   new_cap;
  logic [CW-1:0] dst;
  logic [CW-1:0] push_two_idx;
  logic [CW-1:0] pop_one_idx;

  assign new_cap      = {1'b0, capacity_r} + {2'b0, capacity_r[CW-1:1]};
  assign dst          = src_r + inc_r;
  assign push_two_idx = second_top_r - CW'(1);
  assign pop_one_idx  = first_top_r - CW'(1);
  assign idle         = (state_r == S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    first_top_nxt  = first_top_r;
    second_top_nxt = second_top_r;
    capacity_nxt   = capacity_r;
    grow_count_nxt = grow_count_r;
    src_nxt        = src_r;
    inc_nxt        = inc_r;
    mem_we         = 1'b0;
    mem_waddr      = first_top_r[AW-1:0];
    mem_wdata      = push_value;
    mem_raddr      = src_r[AW-1:0];
    res            = '0;
    res.status     = dss_pkg::ST_OK;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          unique case (dss_pkg::req_t'(req_type))
            dss_pkg::REQ_PUSH_ONE: begin
              res.valid = 1'b1;
              if (first_top_r >= second_top_r ||
                  first_top_r >= CW'(dss_pkg::MAX_CAPACITY)) begin
                res.status = dss_pkg::ST_FULL;
              end else begin
                mem_we        = 1'b1;
                mem_waddr     = first_top_r[AW-1:0];
                first_top_nxt = first_top_r + CW'(1);
              end
            end
            dss_pkg::REQ_PUSH_TWO: begin
              res.valid = 1'b1;
              if (second_top_r <= first_top_r || second_top_r == '0) begin
                res.status = dss_pkg::ST_FULL;
              end else begin
                mem_we         = 1'b1;
                mem_waddr      = push_two_idx[AW-1:0];
                second_top_nxt = push_two_idx;
              end
            end
            dss_pkg::REQ_POP_ONE: begin
              if (first_top_r == '0) begin
                res.valid  = 1'b1;
                res.status = dss_pkg::ST_EMPTY;
              end else begin
                mem_raddr     = pop_one_idx[AW-1:0];
                first_top_nxt = pop_one_idx;
                state_nxt     = S_POP_WAIT;
              end
            end
            dss_pkg::REQ_POP_TWO: begin
              if (second_top_r >= capacity_r) begin
                res.valid  = 1'b1;
                res.status = dss_pkg::ST_EMPTY;
              end else begin
                mem_raddr      = second_top_r[AW-1:0];
                second_top_nxt = second_top_r + CW'(1);
                state_nxt      = S_POP_WAIT;
              end
            end
            dss_pkg::REQ_GROW: begin
              if (first_top_r < second_top_r) begin
                res.valid  = 1'b1;
                res.status = dss_pkg::ST_NO_GROW;
              end else if (grow_count_r >= dss_pkg::GC_W'(dss_pkg::MAX_GROWS) ||
                           new_cap > (CW + 1)'(dss_pkg::MAX_CAPACITY)) begin
                res.valid  = 1'b1;
                res.status = dss_pkg::ST_LIMIT;
              end else begin
                inc_nxt = new_cap[CW-1:0] - capacity_r;
                if (second_top_r == capacity_r) begin
                  // stack two empty: nothing to relocate
                  res.valid      = 1'b1;
                  second_top_nxt = second_top_r + inc_nxt;
                  capacity_nxt   = new_cap[CW-1:0];
                  grow_count_nxt = grow_count_r + dss_pkg::GC_W'(1);
                end else begin
                  src_nxt   = capacity_r - CW'(1);
                  state_nxt = S_MOVE_RD;
                end
              end
            end
            default: begin
              res.valid = 1'b1;
            end
          endcase
        end
      end
      S_POP_WAIT: begin
        res.valid     = 1'b1;
        res.pop_value = mem_rdata;
        state_nxt     = S_IDLE;
      end
      S_MOVE_RD: begin
        mem_raddr = src_r[AW-1:0];
        state_nxt = S_MOVE_WR;
      end
      S_MOVE_WR: begin
        // write the entry just read, shifted up by the increase
        mem_we    = 1'b1;
        mem_waddr = dst[AW-1:0];
        mem_wdata = mem_rdata;
        if (src_r == second_top_r) begin
          res.valid      = 1'b1;
          second_top_nxt = second_top_r + inc_r;
          capacity_nxt   = capacity_r + inc_r;
          grow_count_nxt = grow_count_r + dss_pkg::GC_W'(1);
          state_nxt      = S_IDLE;
        end else begin
          src_nxt   = src_r - CW'(1);
          state_nxt = S_MOVE_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    res.capacity = capacity_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      first_top_r  <= '0;
      second_top_r <= CW'(dss_pkg::RESET_CAPACITY);
      capacity_r   <= CW'(dss_pkg::RESET_CAPACITY);
      grow_count_r <= '0;
    end else begin
      state_r      <= state_nxt;
      first_top_r  <= first_top_nxt;
      second_top_r <= second_top_nxt;
      capacity_r   <= capacity_nxt;
      grow_count_r <= grow_count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    src_r <= src_nxt;
    inc_r <= inc_nxt;
  end

endmodule
`default_nettype wire

// File: rtl/dual_stack_shared_memory.sv
// Timing: push, reject and unknown words raise out_valid in the cycle after they are taken;
//   pops wait in S_POP_WAIT for the RAM read; grows read then write each stack-two entry.
// Throughput: one word in flight; the next word is taken as soon as the sequencer is idle
//   and the output register is empty or being drained, so 1 word/cycle for push streams.
// Reset (rst_n, synchronous, active low): both stacks empty, capacity back to its initial
//   value, grow count zero; store contents are left as they are.
`default_nettype none
module dual_stack_shared_memory (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [dss_pkg::REQ_W-1:0]        in_req_type,
  input  wire logic signed [dss_pkg::KEY_WIDTH-1:0] in_push_value,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic      [dss_pkg::STATUS_W-1:0]     out_status,
  output logic signed [dss_pkg::KEY_WIDTH-1:0]  out_pop_value,
  output logic      [dss_pkg::CAP_W-1:0]        out_capacity_now
);

  logic                             idle;
  logic                             start;
  logic                             mem_we;
  logic [dss_pkg::ADDR_W-1:0]       mem_waddr;
  logic [dss_pkg::KEY_WIDTH-1:0]    mem_wdata;
  logic [dss_pkg::ADDR_W-1:0]       mem_raddr;
  logic [dss_pkg::KEY_WIDTH-1:0]    mem_rdata;
  dss_pkg::result_t                 res;

  // output register
  logic                          out_valid_r;
  dss_pkg::status_t              out_status_r;
  logic [dss_pkg::KEY_WIDTH-1:0] out_pop_value_r;
  logic [dss_pkg::CAP_W-1:0]     out_capacity_r;

  // Take a new word only with the sequencer idle and the output slot free by the
  // time its result lands; only one word is ever in flight, so no result is lost.
  assign in_ready = idle && (!out_valid_r || out_ready);
  assign start    = in_valid && in_ready;

  dss_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .req_type   (in_req_type),
    .push_value (in_push_value),
    .idle       (idle),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata),
    .res        (res)
  );

  // shared store: stack one from the bottom, stack two from the capacity down
  dss_ram #(
    .DEPTH (dss_pkg::MAX_CAPACITY),
    .WIDTH (dss_pkg::KEY_WIDTH),
    .AW    (dss_pkg::ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Load a finished result; otherwise drop valid once the word is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Payload needs no reset; hold it while the word waits.
  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_status_r    <= res.status;
      out_pop_value_r <= res.pop_value;
      out_capacity_r  <= res.capacity;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_pop_value    = out_pop_value_r;
  assign out_capacity_now = out_capacity_r;

endmodule
`default_nettype wire
